FILE: hw/rtl/brsag_pkg.sv
// Shared types and constants for the ring speed average and gust block.
// No dependencies; imported by brsag_div, the top level and the checker.
`timescale 1ns / 1ps
package brsag_pkg;
    localparam int SPEED_W  = 16;
    localparam int CFG_W    = 16;
    localparam int DIV_NW   = 34;
    localparam int DIV_DW   = 18;
    localparam int MS_PER_S = 1000;
    localparam logic [SPEED_W-1:0] SPAN_MAX = 16'hFFFF;
    localparam logic [SPEED_W-1:0] WMS_RST  = 16'd1000;
    localparam logic [SPEED_W-1:0] AVG_RST  = 16'd600;

    typedef enum logic [0:0] {
        CFG_WIN_LEN     = 1'b0,
        CFG_AVG_SECONDS = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;
endpackage

FILE: hw/rtl/brsag_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module brsag_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: hw/rtl/brsag_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on brsag_pkg.
`timescale 1ns / 1ps
module brsag_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  brsag_pkg::t_div_req i_req,
    output logic              o_done,
    output logic [brsag_pkg::DIV_NW-1:0] o_quo
);
    import brsag_pkg::*;

    localparam int CW = $clog2(DIV_NW + 1);

    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [CW-1:0]     r_cnt;
    logic [DIV_DW:0]   w_shift;
    logic [DIV_DW:0]   w_diff;

    assign w_shift = {r_rem, o_quo[DIV_NW-1]};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else if (i_req.start) begin
            r_rem  <= '0;
            r_den  <= i_req.den;
            o_quo  <= i_req.num;
            r_cnt  <= CW'(DIV_NW);
            o_done <= 1'b0;
        end else if (r_cnt != '0) begin
            if (w_shift >= {1'b0, r_den}) begin
                r_rem <= w_diff[DIV_DW-1:0];
                o_quo <= {o_quo[DIV_NW-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[DIV_DW-1:0];
                o_quo <= {o_quo[DIV_NW-2:0], 1'b0};
            end
            r_cnt  <= r_cnt - 1'b1;
            o_done <= (r_cnt == CW'(1));
        end else begin
            o_done <= 1'b0;
        end
    end
endmodule

FILE: hw/rtl/block_ring_speed_average_gust.sv
// Top level of the ring speed average and gust block.
// Depends on brsag_pkg, brsag_ram, brsag_div.
`timescale 1ns / 1ps
// Usage:
// Input channel i_valid/o_stall carries one speed sample per request.
// Output channel o_valid/i_stall carries mean, gust and span-filled flag.
// Configuration: i_cfg_we with i_cfg_idx (0 window length, 1 averaging span)
// and i_cfg_data; a write recomputes the span and clears all history.
// Per sample: the sample is accepted; when a block closes, its slot mean
// is divided; the F filled slots are walked through the slot RAM; and
// the final mean division follows. The serial divider (one bit per cycle)
// and the one-read-per-cycle slot RAM set the work time per sample.
// One sample is in work at a time; o_stall is high while it is, and also
// during reset and in a cycle with a configuration write.
// A finished result sits in the output register; the next sample is
// accepted meanwhile and waits only if its result is ready before the
// previous one was taken. i_stall holds the output unchanged.
// After reset or a configuration write the span derivation runs one or two
// divisions with o_stall high; only reset drops a pending result.
module block_ring_speed_average_gust #(
    parameter int RING_SLOTS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [brsag_pkg::SPEED_W-1:0]  i_speed_sample,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [brsag_pkg::SPEED_W-1:0]  o_mean_speed,
    output logic [brsag_pkg::SPEED_W-1:0]  o_gust_speed,
    output logic                           o_span_filled,
    input  logic                           i_cfg_we,
    input  brsag_pkg::t_cfg_idx            i_cfg_idx,
    input  logic [brsag_pkg::CFG_W-1:0]    i_cfg_data
);
    import brsag_pkg::*;

    localparam int IW  = $clog2(RING_SLOTS);
    localparam int RDW = $clog2(RING_SLOTS + 1);
    localparam logic [31:0] WPS_MUL =
        32'(((64'd1 << 32) + 64'(RING_SLOTS) - 64'd1) / 64'(RING_SLOTS));

    typedef enum logic [3:0] {
        S_DRV0, S_DRV1, S_DRV2, S_DRV4, S_DRV5,
        S_IDLE, S_BLK, S_BLKW, S_WSTART, S_WALK, S_MEAN, S_MEANW, S_OUT
    } t_state;

    t_state          r_state;
    logic [15:0]     r_wms, r_avg, r_span, r_wps, r_wib, r_seen, r_bpeak;
    logic [RDW-1:0]  r_ring, r_filled, r_ridx;
    logic [IW-1:0]   r_wslot;
    logic [31:0]     r_bsum, r_prod;
    logic            r_close, r_v1, r_v2;
    logic [15:0]     r_p2peak, r_gust;
    logic [DIV_NW-1:0] r_acc;
    logic [DIV_DW-1:0] r_cnt;

    t_div_req        w_req;
    logic            w_done;
    logic [DIV_NW-1:0] w_quo;
    logic            w_we;
    logic [31:0]     w_rdata;
    logic [31:0]     n_bsum;
    logic [15:0]     n_wib;
    logic [25:0]     w_ms;
    logic [48:0]     w_wps_prod;

    assign o_stall    = !i_rst_n || i_cfg_we || (r_state != S_IDLE);
    assign w_we       = (r_state == S_BLKW) && w_done;
    assign n_bsum     = r_bsum + 32'(i_speed_sample);
    assign n_wib      = r_wib + 16'd1;
    assign w_ms       = 26'(r_avg) * 26'(MS_PER_S);
    assign w_wps_prod = 49'({1'b0, r_span} + 17'(RING_SLOTS - 1)) * 49'(WPS_MUL);

    always_comb begin
        w_req = '0;
        unique case (r_state)
            S_DRV0: begin
                w_req.start = (r_wms != '0);
                w_req.num   = DIV_NW'(w_ms);
                w_req.den   = DIV_DW'(r_wms);
            end
            S_DRV4: begin
                w_req.start = 1'b1;
                w_req.num   = DIV_NW'(r_span) + DIV_NW'(r_wps) - DIV_NW'(1);
                w_req.den   = DIV_DW'(r_wps);
            end
            S_BLK: begin
                w_req.start = r_close;
                w_req.num   = DIV_NW'(r_bsum);
                w_req.den   = DIV_DW'(r_wps);
            end
            S_MEAN: begin
                w_req.start = 1'b1;
                w_req.num   = r_acc;
                w_req.den   = r_cnt;
            end
            default: w_req = '0;
        endcase
    end

    brsag_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_done),
        .o_quo   (w_quo)
    );

    brsag_ram #(.WIDTH(32), .DEPTH(RING_SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wslot),
        .i_wdata ({r_bpeak, w_quo[15:0]}),
        .i_raddr (r_ridx[IW-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            if (!i_rst_n) begin
                r_wms   <= WMS_RST;
                r_avg   <= AVG_RST;
                o_valid <= 1'b0;
            end else if (i_cfg_idx == CFG_WIN_LEN) begin
                r_wms <= i_cfg_data;
            end else begin
                r_avg <= i_cfg_data;
            end
            if (i_rst_n && o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
            r_state  <= S_DRV0;
            r_bsum   <= '0;
            r_bpeak  <= '0;
            r_wib    <= '0;
            r_filled <= '0;
            r_wslot  <= '0;
            r_seen   <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
        end else begin
            if (o_valid && !i_stall && r_state != S_OUT) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_DRV0: begin
                    if (r_wms == '0) begin
                        r_span <= SPAN_MAX;
                    end
                    r_state <= (r_wms == '0) ? S_DRV2 : S_DRV1;
                end
                S_DRV1: begin
                    if (w_done) begin
                        if (w_quo > DIV_NW'(SPAN_MAX)) begin
                            r_span <= SPAN_MAX;
                        end else if (w_quo == '0) begin
                            r_span <= 16'd1;
                        end else begin
                            r_span <= w_quo[15:0];
                        end
                        r_state <= S_DRV2;
                    end
                end
                S_DRV2: begin
                    r_wps   <= w_wps_prod[47:32];
                    r_state <= S_DRV4;
                end
                S_DRV4: r_state <= S_DRV5;
                S_DRV5: begin
                    if (w_done) begin
                        if (w_quo > DIV_NW'(RING_SLOTS)) begin
                            r_ring <= RDW'(RING_SLOTS);
                        end else if (w_quo == '0) begin
                            r_ring <= RDW'(1);
                        end else begin
                            r_ring <= w_quo[RDW-1:0];
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_bsum  <= n_bsum;
                        r_bpeak <= (i_speed_sample > r_bpeak) ? i_speed_sample : r_bpeak;
                        r_wib   <= n_wib;
                        r_close <= (n_wib >= r_wps);
                        if (r_seen != SPAN_MAX) begin
                            r_seen <= r_seen + 16'd1;
                        end
                        r_state <= S_BLK;
                    end
                end
                S_BLK: r_state <= r_close ? S_BLKW : S_WSTART;
                S_BLKW: begin
                    if (w_done) begin
                        r_bsum  <= '0;
                        r_bpeak <= '0;
                        r_wib   <= '0;
                        if (RDW'(r_wslot) + RDW'(1) >= r_ring) begin
                            r_wslot <= '0;
                        end else begin
                            r_wslot <= r_wslot + IW'(1);
                        end
                        if (r_filled < r_ring) begin
                            r_filled <= r_filled + RDW'(1);
                        end
                        r_state <= S_WSTART;
                    end
                end
                S_WSTART: begin
                    r_acc   <= DIV_NW'(r_bsum);
                    r_cnt   <= DIV_DW'(r_wib);
                    r_gust  <= r_bpeak;
                    r_ridx  <= '0;
                    r_v1    <= 1'b0;
                    r_v2    <= 1'b0;
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    r_v1 <= (r_ridx < r_filled);
                    if (r_ridx < r_filled) begin
                        r_ridx <= r_ridx + RDW'(1);
                    end
                    r_v2     <= r_v1;
                    r_prod   <= w_rdata[15:0] * r_wps;
                    r_p2peak <= w_rdata[31:16];
                    if (r_v2) begin
                        r_acc <= r_acc + DIV_NW'(r_prod);
                        r_cnt <= r_cnt + DIV_DW'(r_wps);
                        if (r_p2peak > r_gust) begin
                            r_gust <= r_p2peak;
                        end
                    end
                    if (r_ridx == r_filled && !r_v1 && !r_v2) begin
                        r_state <= S_MEAN;
                    end
                end
                S_MEAN: r_state <= S_MEANW;
                S_MEANW: begin
                    if (w_done) begin
                        r_acc   <= w_quo;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!o_valid || !i_stall) begin
                        o_valid       <= 1'b1;
                        o_mean_speed  <= (r_cnt == '0) ? '0 : r_acc[15:0];
                        o_gust_speed  <= r_gust;
                        o_span_filled <= (r_seen >= r_span);
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_DRV0;
            endcase
        end
    end
endmodule

FILE: hw/rtl/brsag_chk.sv
// Port-level checker for the ring speed average and gust block, with bind.
// Depends on brsag_pkg and block_ring_speed_average_gust.
`timescale 1ns / 1ps
module brsag_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [brsag_pkg::SPEED_W-1:0] o_mean_speed,
    input logic [brsag_pkg::SPEED_W-1:0] o_gust_speed,
    input logic                          o_span_filled
);
    import brsag_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_mean_speed)
            && $stable(o_gust_speed) && $stable(o_span_filled))
        else $error("stalled result changed");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid && o_stall)
        else $error("reset left result or intake open");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second request taken during work");

    a_gust: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_gust_speed >= o_mean_speed)
        else $error("mean above gust");
endmodule

bind block_ring_speed_average_gust brsag_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_mean_speed  (o_mean_speed),
    .o_gust_speed  (o_gust_speed),
    .o_span_filled (o_span_filled)
);
